FILE: src/dr32_pkg.sv
// Shared types and constants for the pipelined divide / remainder unit.
package dr32_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REQ_DIVU = 2'd0,
    REQ_REMU = 2'd1,
    REQ_DIV  = 2'd2,
    REQ_REM  = 2'd3
  } req_type_t;

  // Control that travels beside the operands through every stage.
  typedef struct packed {
    logic      valid;
    req_type_t op;
    logic      neg_q;
    logic      neg_r;
  } ctl_t;

endpackage

FILE: src/dr32_div_stage.sv
// One restoring-division step: produces one quotient bit and registers it.
module dr32_div_stage #(
  parameter int W = dr32_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  dr32_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  rem_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  output dr32_pkg::ctl_t ctl_o,
  output logic [W-1:0]  rem_o,
  output logic [W-1:0]  num_o,
  output logic [W-1:0]  den_o
);

  dr32_pkg::ctl_t ctl_r;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   num_r, num_nxt;
  logic [W-1:0]   den_r;
  logic [W:0]     trial;
  logic [W+1:0]   diff;
  logic           qbit;

  // The dividend shifts out at the top while quotient bits shift in below,
  // so after the last step the numerator register holds the quotient.
  // A zero divisor always subtracts, which yields all ones and the dividend.
  always_comb begin
    trial   = {rem_i, num_i[W-1]};
    diff    = {1'b0, trial} - {2'b00, den_i};
    qbit    = ~diff[W+1];
    rem_nxt = qbit ? diff[W-1:0] : trial[W-1:0];
    num_nxt = {num_i[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      den_r <= den_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign num_o = num_r;
  assign den_o = den_r;

endmodule

FILE: src/divide_remainder_32.sv
// Pipelined divide / remainder unit: unsigned and signed quotient and remainder.
//
//   channel | direction | handshake         | payload
//   in      | request   | in_valid/in_stall | in_req_type, in_dividend, in_divisor
//   out     | result    | out_valid/out_stall | out_result
//
// One request enters per cycle while the input is not stalled; the pipeline has
// one quotient bit per stage plus an operand-magnitude stage and a sign-fix stage.
// Reset clears only the valid bits of the stages and of the output register.
// A stall while a result waits in the output register freezes the whole
// pipeline and stalls the input; a stall on an empty output register does not.
module divide_remainder_32 #(
  parameter int DATA_WIDTH = dr32_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [DATA_WIDTH-1:0] in_dividend,
  input  logic [DATA_WIDTH-1:0] in_divisor,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_result
);

  localparam int W = DATA_WIDTH;

  dr32_pkg::ctl_t      ctl_s [0:W];
  logic [W-1:0]        rem_s [0:W];
  logic [W-1:0]        num_s [0:W];
  logic [W-1:0]        den_s [0:W];

  dr32_pkg::ctl_t      ctl_in;
  dr32_pkg::ctl_t      ctl0_r;
  logic [W-1:0]        mag_a, mag_b;
  logic [W-1:0]        num0_r, den0_r;
  logic                is_signed;
  logic                en;
  logic                out_valid_r;
  logic [W-1:0]        out_result_r;
  logic [W-1:0]        sel, res_nxt;
  logic                want_q, neg;

  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  // Stage 0: operand magnitudes and the signs to apply at the end.
  always_comb begin
    ctl_in.op   = dr32_pkg::req_type_t'(in_req_type);
    is_signed   = (ctl_in.op == dr32_pkg::REQ_DIV) || (ctl_in.op == dr32_pkg::REQ_REM);
    ctl_in.valid = in_valid;
    ctl_in.neg_q = is_signed & (in_dividend[W-1] ^ in_divisor[W-1]);
    ctl_in.neg_r = is_signed & in_dividend[W-1];
    mag_a = (is_signed && in_dividend[W-1]) ? (~in_dividend + 1'b1) : in_dividend;
    mag_b = (is_signed && in_divisor[W-1])  ? (~in_divisor + 1'b1)  : in_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
    end else if (en) begin
      ctl0_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= mag_a;
      den0_r <= mag_b;
    end
  end

  assign ctl_s[0] = ctl0_r;
  assign rem_s[0] = '0;
  assign num_s[0] = num0_r;
  assign den_s[0] = den0_r;

  for (genvar i = 0; i < W; i++) begin : g_step
    dr32_div_stage #(.W(W)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_s[i]),
      .rem_i (rem_s[i]),
      .num_i (num_s[i]),
      .den_i (den_s[i]),
      .ctl_o (ctl_s[i+1]),
      .rem_o (rem_s[i+1]),
      .num_o (num_s[i+1]),
      .den_o (den_s[i+1])
    );
  end

  // Last stage: pick quotient or remainder and restore the sign.
  always_comb begin
    want_q  = (ctl_s[W].op == dr32_pkg::REQ_DIVU) || (ctl_s[W].op == dr32_pkg::REQ_DIV);
    sel     = want_q ? num_s[W] : rem_s[W];
    neg     = want_q ? ctl_s[W].neg_q : ctl_s[W].neg_r;
    res_nxt = neg ? (~sel + 1'b1) : sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_s[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[W].valid && (den_s[W] != '0) |-> (rem_s[W] < den_s[W]))
    else $error("partial remainder not below divisor");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && ctl_s[W].valid |=> out_valid_r)
    else $error("finished request lost before output register");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_s[W]) && $stable(num_s[W]) && $stable(ctl0_r))
    else $error("pipeline moved while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !ctl0_r.valid)
    else $error("valid bits not cleared by reset");

endmodule
